### src/frustum_box_cull_unit_macros.svh
`ifndef FRUSTUM_BOX_CULL_UNIT_MACROS_SVH
`define FRUSTUM_BOX_CULL_UNIT_MACROS_SVH

// same-cycle implication, clocked on i_clk, off while in reset
`define FCU_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("frustum cull: same-cycle check failed");

// next-cycle implication
`define FCU_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("frustum cull: next-cycle check failed");

`endif

### src/fcull_pkg.sv
`timescale 1ns / 1ps
package fcull_pkg;

    localparam int FCULL_FRAC_BITS = 16;
    localparam int PLANE_COUNT     = 6;
    localparam int PLANE_W         = $clog2(PLANE_COUNT);
    localparam int NORM_FRAC       = 16;

    localparam logic [15:0] THR_RESET = 16'd655;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_TEST = 1'b1;

    localparam logic [3:0]         LAST_ELEM  = 4'd15;
    localparam logic [PLANE_W-1:0] LAST_PLANE = PLANE_W'(PLANE_COUNT - 1);
    localparam logic [1:0]         COMP_OFF   = 2'd3;
    localparam logic [1:0]         COMP_LAST_N = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RD_A,
        S_RD_B,
        S_COMB,
        S_SQ_MUL,
        S_SQ_ADD,
        S_SQRT,
        S_DIV_INIT,
        S_DIV,
        S_DIV_STORE,
        S_ROW,
        S_T_RUN,
        S_T_LAST,
        S_T_DONE
    } t_state;

    typedef struct packed {
        logic               mem_we;
        logic               mem_rd;
        logic [3:0]         mem_addr;
        logic               lat_a;
        logic               comb_en;
        logic               sq_clr;
        logic               sq_mul;
        logic               sq_add;
        logic               sqrt_init;
        logic               sqrt_step;
        logic               div_init;
        logic               div_step;
        logic               div_store;
        logic               row_write;
        logic               row_zero;
        logic               box_load;
        logic               test_clr;
        logic               test_mul;
        logic               test_cmp;
        logic               out_load;
        logic [1:0]         comp;
        logic [PLANE_W-1:0] plane;
    } t_cmd;

    typedef struct packed {
        logic sqrt_last;
        logic div_last;
        logic len_zero;
    } t_status;

endpackage

### src/fcull_if.sv
`timescale 1ns / 1ps
interface fcull_in_if;
    logic               valid;
    logic               ready;
    logic               operation;
    logic [3:0]         element_index;
    logic signed [31:0] element_value;
    logic signed [31:0] min_x;
    logic signed [31:0] min_y;
    logic signed [31:0] min_z;
    logic signed [31:0] max_x;
    logic signed [31:0] max_y;
    logic signed [31:0] max_z;

    modport source (output valid, operation, element_index, element_value,
                    min_x, min_y, min_z, max_x, max_y, max_z, input ready);
    modport sink   (input valid, operation, element_index, element_value,
                    min_x, min_y, min_z, max_x, max_y, max_z, output ready);
endinterface

interface fcull_out_if;
    logic valid;
    logic ready;
    logic inside_res;

    modport source (output valid, inside_res, input ready);
    modport sink   (input valid, inside_res, output ready);
endinterface

interface fcull_cfg_if;
    logic        valid;
    logic        ready;
    logic [15:0] data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

### src/fcull_ctrl.sv
`timescale 1ns / 1ps
module fcull_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_in_op,
    input  logic [3:0]        i_in_index,
    input  logic              i_out_ready,
    input  fcull_pkg::t_status i_status,
    output logic              o_in_ready,
    output logic              o_out_valid,
    output fcull_pkg::t_cmd   o_cmd
);
    import fcull_pkg::*;

    t_state             r_state, n_state;
    logic [PLANE_W-1:0] r_k, n_k;
    logic [1:0]         r_j, n_j;
    logic               r_out_valid;
    logic               w_accept;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign w_accept    = i_in_valid && (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_k         <= '0;
            r_j         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_k     <= n_k;
            r_j     <= n_j;
            if (o_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_comb begin
        n_state = r_state;
        n_k     = r_k;
        n_j     = r_j;
        o_cmd   = '0;
        o_cmd.comp  = r_j;
        o_cmd.plane = r_k;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_k = '0;
                    n_j = '0;
                    if (i_in_op == OP_LOAD) begin
                        o_cmd.mem_we = 1'b1;
                        if (i_in_index == LAST_ELEM) begin
                            n_state = S_RD_A;
                        end
                    end else begin
                        o_cmd.box_load = 1'b1;
                        o_cmd.test_clr = 1'b1;
                        n_state        = S_T_RUN;
                    end
                end
            end
            S_RD_A: begin
                o_cmd.mem_rd   = 1'b1;
                o_cmd.mem_addr = {r_j, 2'b11};
                n_state        = S_RD_B;
            end
            S_RD_B: begin
                o_cmd.lat_a    = 1'b1;
                o_cmd.mem_rd   = 1'b1;
                o_cmd.mem_addr = {r_j, r_k[2:1]};
                n_state        = S_COMB;
            end
            S_COMB: begin
                o_cmd.comb_en = 1'b1;
                if (r_j == COMP_OFF) begin
                    o_cmd.sq_clr = 1'b1;
                    n_j          = '0;
                    n_state      = S_SQ_MUL;
                end else begin
                    n_j     = r_j + 2'd1;
                    n_state = S_RD_A;
                end
            end
            S_SQ_MUL: begin
                o_cmd.sq_mul = 1'b1;
                n_state      = S_SQ_ADD;
            end
            S_SQ_ADD: begin
                o_cmd.sq_add = 1'b1;
                if (r_j == COMP_LAST_N) begin
                    o_cmd.sqrt_init = 1'b1;
                    n_j             = '0;
                    n_state         = S_SQRT;
                end else begin
                    n_j     = r_j + 2'd1;
                    n_state = S_SQ_MUL;
                end
            end
            S_SQRT: begin
                o_cmd.sqrt_step = 1'b1;
                if (i_status.sqrt_last) begin
                    n_state = S_DIV_INIT;
                end
            end
            S_DIV_INIT: begin
                if (i_status.len_zero) begin
                    o_cmd.row_zero = 1'b1;
                    n_j            = '0;
                    if (r_k == LAST_PLANE) begin
                        n_state = S_IDLE;
                    end else begin
                        n_k     = r_k + 1'b1;
                        n_state = S_RD_A;
                    end
                end else begin
                    o_cmd.div_init = 1'b1;
                    n_state        = S_DIV;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_status.div_last) begin
                    n_state = S_DIV_STORE;
                end
            end
            S_DIV_STORE: begin
                o_cmd.div_store = 1'b1;
                if (r_j == COMP_OFF) begin
                    n_state = S_ROW;
                end else begin
                    n_j     = r_j + 2'd1;
                    n_state = S_DIV_INIT;
                end
            end
            S_ROW: begin
                o_cmd.row_write = 1'b1;
                n_j             = '0;
                if (r_k == LAST_PLANE) begin
                    n_state = S_IDLE;
                end else begin
                    n_k     = r_k + 1'b1;
                    n_state = S_RD_A;
                end
            end
            S_T_RUN: begin
                o_cmd.test_mul = 1'b1;
                o_cmd.test_cmp = (r_k != '0);
                if (r_k == LAST_PLANE) begin
                    n_state = S_T_LAST;
                end else begin
                    n_k = r_k + 1'b1;
                end
            end
            S_T_LAST: begin
                o_cmd.test_cmp = 1'b1;
                n_state        = S_T_DONE;
            end
            S_T_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

### src/fcull_datapath.sv
`timescale 1ns / 1ps
module fcull_datapath #(
    parameter int FRAC_BITS = fcull_pkg::FCULL_FRAC_BITS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  fcull_pkg::t_cmd    i_cmd,
    input  logic [3:0]         i_index,
    input  logic signed [31:0] i_value,
    input  logic signed [31:0] i_min_x,
    input  logic signed [31:0] i_min_y,
    input  logic signed [31:0] i_min_z,
    input  logic signed [31:0] i_max_x,
    input  logic signed [31:0] i_max_y,
    input  logic signed [31:0] i_max_z,
    input  logic               i_cfg_valid,
    input  logic [15:0]        i_cfg_data,
    output fcull_pkg::t_status o_status,
    output logic               o_inside
);
    import fcull_pkg::*;

    localparam int SHIFT_MAX  = (FRAC_BITS > NORM_FRAC) ? FRAC_BITS : NORM_FRAC;
    localparam int MAG_W      = 33;
    localparam int SUM_W      = 66;
    localparam int SQ_STEPS   = 34;
    localparam int SX_W       = 2 * SQ_STEPS;
    localparam int ROOT_W     = SQ_STEPS;
    localparam int SREM_W     = ROOT_W + 2;
    localparam int NUM_W      = MAG_W + SHIFT_MAX + 1;
    localparam int DCNT_W     = $clog2(NUM_W);
    localparam int SCNT_W     = $clog2(SQ_STEPS);
    localparam logic [NUM_W-1:0] NRM_MAX = NUM_W'((64'd1 << 17) - 64'd1);
    localparam logic [NUM_W-1:0] OFF_MAX = NUM_W'((64'd1 << 31) - 64'd1);

    // matrix store, one write and one registered read port
    logic signed [31:0] r_mem [16];
    logic signed [31:0] r_rdata;
    logic signed [31:0] r_a;
    logic signed [32:0] r_v [4];

    logic [2*MAG_W-1:0] r_sqp;
    logic [SUM_W-1:0]   r_sum;
    logic [MAG_W-1:0]   w_mag;

    logic [SX_W-1:0]    r_sx;
    logic [SREM_W-1:0]  r_srem;
    logic [ROOT_W-1:0]  r_root;
    logic [SCNT_W-1:0]  r_scnt;
    logic [SREM_W+1:0]  w_srem2;
    logic [SREM_W+1:0]  w_strial;

    logic [NUM_W-1:0]   r_dnum;
    logic [NUM_W-1:0]   r_dq;
    logic [ROOT_W-1:0]  r_drem;
    logic [DCNT_W-1:0]  r_dcnt;
    logic               r_dneg;
    logic [NUM_W-1:0]   w_num;
    logic [ROOT_W:0]    w_drem2;
    logic               w_dge;
    logic [NUM_W-1:0]   w_lim;
    logic [32:0]        w_qs;
    logic [32:0]        w_res;
    logic signed [31:0] r_res [4];

    logic signed [17:0] r_nrm [PLANE_COUNT][3];
    logic signed [31:0] r_off [PLANE_COUNT];

    logic signed [31:0] r_bmin [3];
    logic signed [31:0] r_bmax [3];
    logic signed [49:0] w_prd  [3];
    logic signed [49:0] r_prd  [3];
    logic signed [31:0] r_poff;
    logic signed [52:0] w_acc;
    logic signed [52:0] w_thr;
    logic [15:0]        r_thr;
    logic               r_fail;
    logic               r_inside;

    always_ff @(posedge i_clk) begin
        if (i_cmd.mem_we) begin
            r_mem[i_index] <= i_value;
        end
        if (i_cmd.mem_rd) begin
            r_rdata <= r_mem[i_cmd.mem_addr];
        end
    end

    // plane row: n = m(4j+3) +/- m(4j+r); odd planes subtract
    always_ff @(posedge i_clk) begin
        if (i_cmd.lat_a) begin
            r_a <= r_rdata;
        end
        if (i_cmd.comb_en) begin
            if (i_cmd.plane[0]) begin
                r_v[i_cmd.comp] <= {r_a[31], r_a} - {r_rdata[31], r_rdata};
            end else begin
                r_v[i_cmd.comp] <= {r_a[31], r_a} + {r_rdata[31], r_rdata};
            end
        end
    end

    assign w_mag = r_v[i_cmd.comp][32] ? MAG_W'(-r_v[i_cmd.comp])
                                       : MAG_W'(r_v[i_cmd.comp]);

    always_ff @(posedge i_clk) begin
        if (i_cmd.sq_clr) begin
            r_sum <= '0;
        end else if (i_cmd.sq_add) begin
            r_sum <= r_sum + SUM_W'(r_sqp);
        end
        if (i_cmd.sq_mul) begin
            r_sqp <= w_mag * w_mag;
        end
    end

    // digit-by-digit square root, two radicand bits per step
    assign w_srem2  = {r_srem, r_sx[SX_W-1 -: 2]};
    assign w_strial = (SREM_W + 2)'({r_root, 2'b01});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scnt <= '0;
        end else if (i_cmd.sqrt_init) begin
            r_scnt <= '0;
        end else if (i_cmd.sqrt_step) begin
            r_scnt <= r_scnt + 1'b1;
        end
    end

    // init comes with the last square add, so take that square in directly
    always_ff @(posedge i_clk) begin
        if (i_cmd.sqrt_init) begin
            r_sx   <= SX_W'(r_sum + SUM_W'(r_sqp));
            r_srem <= '0;
            r_root <= '0;
        end else if (i_cmd.sqrt_step) begin
            r_sx <= r_sx << 2;
            if (w_srem2 >= w_strial) begin
                r_srem <= SREM_W'(w_srem2 - w_strial);
                r_root <= {r_root[ROOT_W-2:0], 1'b1};
            end else begin
                r_srem <= SREM_W'(w_srem2);
                r_root <= {r_root[ROOT_W-2:0], 1'b0};
            end
        end
    end

    // restoring divide of round(|n| * 2^shift / len)
    assign w_num = (i_cmd.comp == COMP_OFF)
                 ? ((NUM_W'(w_mag) << FRAC_BITS) + NUM_W'(r_root >> 1))
                 : ((NUM_W'(w_mag) << NORM_FRAC) + NUM_W'(r_root >> 1));
    assign w_drem2 = {r_drem, r_dnum[NUM_W-1]};
    assign w_dge   = (w_drem2 >= {1'b0, r_root});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dcnt <= '0;
        end else if (i_cmd.div_init) begin
            r_dcnt <= '0;
        end else if (i_cmd.div_step) begin
            r_dcnt <= r_dcnt + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_init) begin
            r_dnum <= w_num;
            r_dq   <= '0;
            r_drem <= '0;
            r_dneg <= r_v[i_cmd.comp][32];
        end else if (i_cmd.div_step) begin
            r_dnum <= r_dnum << 1;
            r_dq   <= {r_dq[NUM_W-2:0], w_dge};
            r_drem <= w_dge ? ROOT_W'(w_drem2 - {1'b0, r_root}) : ROOT_W'(w_drem2);
        end
    end

    always_comb begin
        w_lim = (i_cmd.comp == COMP_OFF) ? OFF_MAX : NRM_MAX;
        if (r_dneg) begin
            w_lim = w_lim + 1'b1;
        end
        w_qs  = (r_dq > w_lim) ? 33'(w_lim) : 33'(r_dq);
        w_res = r_dneg ? (33'd0 - w_qs) : w_qs;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_store) begin
            r_res[i_cmd.comp] <= w_res[31:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int p = 0; p < PLANE_COUNT; p++) begin
                r_off[p] <= '0;
                for (int c = 0; c < 3; c++) begin
                    r_nrm[p][c] <= '0;
                end
            end
        end else if (i_cmd.row_zero) begin
            r_off[i_cmd.plane] <= '0;
            for (int c = 0; c < 3; c++) begin
                r_nrm[i_cmd.plane][c] <= '0;
            end
        end else if (i_cmd.row_write) begin
            r_off[i_cmd.plane] <= r_res[3];
            for (int c = 0; c < 3; c++) begin
                r_nrm[i_cmd.plane][c] <= r_res[c][17:0];
            end
        end
    end

    // box test: stage one multiplies, stage two sums and compares
    always_ff @(posedge i_clk) begin
        if (i_cmd.box_load) begin
            r_bmin[0] <= i_min_x;
            r_bmin[1] <= i_min_y;
            r_bmin[2] <= i_min_z;
            r_bmax[0] <= i_max_x;
            r_bmax[1] <= i_max_y;
            r_bmax[2] <= i_max_z;
        end
    end

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            // zero normal counts as non-negative
            w_prd[c] = r_nrm[i_cmd.plane][c]
                     * (r_nrm[i_cmd.plane][c][17] ? r_bmin[c] : r_bmax[c]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.test_mul) begin
            r_poff <= r_off[i_cmd.plane];
            for (int c = 0; c < 3; c++) begin
                r_prd[c] <= w_prd[c];
            end
        end
    end

    assign w_acc = 53'(r_prd[0]) + 53'(r_prd[1]) + 53'(r_prd[2])
                 + $signed({{5{r_poff[31]}}, r_poff, 16'd0});
    assign w_thr = $signed({21'd0, r_thr, 16'd0});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr    <= THR_RESET;
            r_fail   <= 1'b0;
            r_inside <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_thr <= i_cfg_data;
            end
            if (i_cmd.test_clr) begin
                r_fail <= 1'b0;
            end else if (i_cmd.test_cmp && (w_acc < w_thr)) begin
                r_fail <= 1'b1;
            end
            if (i_cmd.out_load) begin
                r_inside <= !r_fail;
            end
        end
    end

    assign o_inside           = r_inside;
    assign o_status.sqrt_last = (r_scnt == SCNT_W'(SQ_STEPS - 1));
    assign o_status.div_last  = (r_dcnt == DCNT_W'(NUM_W - 1));
    assign o_status.len_zero  = (r_root == '0);

endmodule

### src/frustum_box_cull_unit.sv
`timescale 1ns / 1ps
// Channel   Dir  Contents
// i_in      in   operation, element_index, element_value, min_x..max_z
// o_out     out  inside_res
// i_cfg     in   inside_threshold (16 bits), always ready
//
// Box test: one plane per cycle through the shared three-lane multiply stage
// plus one compare stage. Other loads leave i_in.ready high. Element 15
// derives six planes, each from reads and squares, 34 root steps, then four
// divides and a row write, or a zeroed row where the length is zero.
// i_in.ready is low while a request is in progress.
// A stalled output holds the next test at its last stage; reset clears planes.
module frustum_box_cull_unit #(
    parameter int FRAC_BITS = fcull_pkg::FCULL_FRAC_BITS
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    fcull_in_if.sink    i_in,
    fcull_out_if.source o_out,
    fcull_cfg_if.sink   i_cfg
);
    import fcull_pkg::*;

    `include "frustum_box_cull_unit_macros.svh"

    t_cmd    w_cmd;
    t_status w_status;
    logic    w_in_ready;
    logic    w_out_valid;
    logic    w_inside;
    logic    w_in_fire;
    logic    w_in_last;

    fcull_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_in_op     (i_in.operation),
        .i_in_index  (i_in.element_index),
        .i_out_ready (o_out.ready),
        .i_status    (w_status),
        .o_in_ready  (w_in_ready),
        .o_out_valid (w_out_valid),
        .o_cmd       (w_cmd)
    );

    fcull_datapath #(
        .FRAC_BITS (FRAC_BITS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_index     (i_in.element_index),
        .i_value     (i_in.element_value),
        .i_min_x     (i_in.min_x),
        .i_min_y     (i_in.min_y),
        .i_min_z     (i_in.min_z),
        .i_max_x     (i_in.max_x),
        .i_max_y     (i_in.max_y),
        .i_max_z     (i_in.max_z),
        .i_cfg_valid (i_cfg.valid),
        .i_cfg_data  (i_cfg.data),
        .o_status    (w_status),
        .o_inside    (w_inside)
    );

    assign i_in.ready       = w_in_ready;
    assign i_cfg.ready      = 1'b1;
    assign o_out.valid      = w_out_valid;
    assign o_out.inside_res = w_inside;

    assign w_in_fire = i_in.valid && i_in.ready;
    assign w_in_last = (i_in.element_index == LAST_ELEM);

    `FCU_ASSERT_NEXT(a_test_busy, w_in_fire && i_in.operation == OP_TEST, !i_in.ready)
    `FCU_ASSERT_NEXT(a_load_quick, w_in_fire && i_in.operation == OP_LOAD && !w_in_last, i_in.ready)
    `FCU_ASSERT_NEXT(a_derive_busy, w_in_fire && i_in.operation == OP_LOAD && w_in_last, !i_in.ready)
    `FCU_ASSERT_NEXT(a_result_shown, w_cmd.out_load, o_out.valid)

endmodule

### verif/tb_frustum_box_cull_unit.sv
`timescale 1ns / 1ps
module tb_frustum_box_cull_unit;
    import fcull_pkg::*;

    localparam int  CYCLE_LIMIT = 1000000;
    localparam int  DERIVE_WAIT = 2000;
    localparam int  HOLD_CYCLES = 400;
    localparam longint ONE      = 64'sd1 << FCULL_FRAC_BITS;

    typedef struct {
        logic               op;
        logic [3:0]         idx;
        logic signed [31:0] val;
        logic signed [31:0] corner[6];   // min x,y,z then max x,y,z
    } t_cull_req;

    logic i_clk;
    logic i_rst_n;

    fcull_in_if  in_ch();
    fcull_out_if out_ch();
    fcull_cfg_if cfg_ch();

    frustum_box_cull_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source),
        .i_cfg   (cfg_ch.sink)
    );

    // predictor state
    longint    mat[16];
    longint    norm[18];
    longint    offs[6];
    longint    thr_q;

    t_cull_req pend_q[$];
    logic      inside_q[$];
    t_cull_req cur_req;
    int        src_idle;
    int        sink_idle;
    int        hold_req;
    int        hold_seen;
    int        hold_left;
    int        errors;
    int        cycles;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic longint mag_of(longint v);
        return v < 0 ? -v : v;
    endfunction

    function automatic longint round_div(longint v, longint den, int sh,
                                         longint lo_lim, longint hi_lim);
        longint q;
        q = ((mag_of(v) << sh) + den / 2) / den;
        if (v < 0)
            return (q > -lo_lim) ? lo_lim : -q;
        return (q > hi_lim) ? hi_lim : q;
    endfunction

    task automatic derive_planes();
        longint       n[3];
        longint       d;
        longint       s;
        logic [71:0]  sum;
        logic [71:0]  cand;
        logic [35:0]  root;
        logic [35:0]  c;
        for (int k = 0; k < PLANE_COUNT; k++) begin
            s    = (k % 2) ? -1 : 1;
            n[0] = mat[3]  + s * mat[k/2];
            n[1] = mat[7]  + s * mat[4 + k/2];
            n[2] = mat[11] + s * mat[8 + k/2];
            d    = mat[15] + s * mat[12 + k/2];
            sum  = '0;
            for (int j = 0; j < 3; j++)
                sum += 72'(mag_of(n[j])) * 72'(mag_of(n[j]));
            root = '0;
            for (int b = 34; b >= 0; b--) begin
                c    = root | (36'd1 << b);
                cand = 72'(c) * 72'(c);
                if (cand <= sum)
                    root = c;
            end
            if (root == 0) begin
                for (int j = 0; j < 3; j++)
                    norm[k*3 + j] = 0;
                offs[k] = 0;
            end else begin
                for (int j = 0; j < 3; j++)
                    norm[k*3 + j] = round_div(n[j], longint'(root), NORM_FRAC,
                                              -64'sd131072, 64'sd131071);
                offs[k] = round_div(d, longint'(root), FCULL_FRAC_BITS,
                                    -64'sd2147483648, 64'sd2147483647);
            end
        end
    endtask

    // update state on a load, queue the verdict on a test
    task automatic apply_request(t_cull_req r);
        longint acc;
        logic   verdict;
        if (r.op == OP_LOAD) begin
            mat[r.idx] = longint'(r.val);
            if (r.idx == LAST_ELEM)
                derive_planes();
        end else begin
            verdict = 1'b1;
            for (int k = 0; k < PLANE_COUNT; k++) begin
                acc = offs[k] * ONE;
                for (int j = 0; j < 3; j++)
                    acc += norm[k*3 + j] * longint'(norm[k*3 + j] >= 0 ?
                                                    r.corner[3 + j] : r.corner[j]);
                if (acc < thr_q * ONE)
                    verdict = 1'b0;
            end
            inside_q.push_back(verdict);
        end
    endtask

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid         <= 1'b0;
            in_ch.operation     <= OP_LOAD;
            in_ch.element_index <= '0;
            in_ch.element_value <= '0;
            in_ch.min_x <= '0; in_ch.min_y <= '0; in_ch.min_z <= '0;
            in_ch.max_x <= '0; in_ch.max_y <= '0; in_ch.max_z <= '0;
        end else begin
            if (in_ch.valid && in_ch.ready)
                apply_request(cur_req);
            if (!in_ch.valid || in_ch.ready) begin
                if (pend_q.size() != 0 && $urandom_range(99) >= src_idle) begin
                    cur_req              = pend_q.pop_front();
                    in_ch.valid         <= 1'b1;
                    in_ch.operation     <= cur_req.op;
                    in_ch.element_index <= cur_req.idx;
                    in_ch.element_value <= cur_req.val;
                    in_ch.min_x <= cur_req.corner[0];
                    in_ch.min_y <= cur_req.corner[1];
                    in_ch.min_z <= cur_req.corner[2];
                    in_ch.max_x <= cur_req.corner[3];
                    in_ch.max_y <= cur_req.corner[4];
                    in_ch.max_z <= cur_req.corner[5];
                end else begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    // monitor and result check
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
            hold_seen    = 0;
            hold_left    = 0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                if (inside_q.size() == 0) begin
                    $error("inside_res: unexpected result %0b", out_ch.inside_res);
                    errors++;
                end else if (out_ch.inside_res !== inside_q[0]) begin
                    $error("inside_res: expected %0b, actual %0b",
                           inside_q[0], out_ch.inside_res);
                    errors++;
                    void'(inside_q.pop_front());
                end else begin
                    void'(inside_q.pop_front());
                end
            end
            if (hold_seen != hold_req) begin
                hold_seen = hold_req;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= ($urandom_range(99) >= sink_idle);
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    function automatic logic signed [31:0] rand_coord(int span);
        if ($urandom_range(9) == 0)
            return $urandom;
        return $signed($urandom_range(2 * span)) - span;
    endfunction

    function automatic t_cull_req load_req(int idx, logic signed [31:0] v);
        t_cull_req r;
        r.op  = OP_LOAD;
        r.idx = 4'(idx);
        r.val = v;
        for (int j = 0; j < 6; j++)
            r.corner[j] = $urandom;
        return r;
    endfunction

    function automatic t_cull_req box_req(logic signed [31:0] lo_x, lo_y, lo_z,
                                          hi_x, hi_y, hi_z);
        t_cull_req r;
        r.op  = OP_TEST;
        r.idx = 4'($urandom);
        r.val = $urandom;
        r.corner[0] = lo_x; r.corner[1] = lo_y; r.corner[2] = lo_z;
        r.corner[3] = hi_x; r.corner[4] = hi_y; r.corner[5] = hi_z;
        return r;
    endfunction

    function automatic t_cull_req rand_box();
        logic signed [31:0] ctr[3];
        logic signed [31:0] half[3];
        if ($urandom_range(9) == 0)
            return box_req($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
        for (int j = 0; j < 3; j++) begin
            ctr[j]  = rand_coord(32'sd40 << 16);
            half[j] = $urandom_range(32'd6 << 16);
        end
        return box_req(ctr[0] - half[0], ctr[1] - half[1], ctr[2] - half[2],
                       ctr[0] + half[0], ctr[1] + half[1], ctr[2] + half[2]);
    endfunction

    // one matrix: elements 0..14 shuffled, stray rewrites, then element 15
    task automatic push_matrix();
        int                 order[15];
        int                 a;
        int                 t;
        logic signed [31:0] v[16];
        for (int i = 0; i < 16; i++)
            v[i] = ($urandom_range(7) == 0) ? $urandom : rand_coord(32'sd3 << 16);
        if ($urandom_range(7) == 0) begin
            // right plane collapses to zero length
            v[0] = v[3]; v[4] = v[7]; v[8] = v[11];
        end
        for (int i = 0; i < 15; i++)
            order[i] = i;
        for (int i = 14; i > 0; i--) begin
            a = $urandom_range(i);
            t = order[i]; order[i] = order[a]; order[a] = t;
        end
        for (int i = 0; i < 15; i++) begin
            pend_q.push_back(load_req(order[i], v[order[i]]));
            if ($urandom_range(19) == 0)
                pend_q.push_back(load_req($urandom_range(14), $urandom));
        end
        pend_q.push_back(load_req(LAST_ELEM, v[15]));
    endtask

    task automatic push_random(int n_boxes);
        int left;
        left = n_boxes;
        while (left > 0) begin
            push_matrix();
            for (int i = $urandom_range(15, 40); i > 0 && left > 0; i--) begin
                pend_q.push_back(rand_box());
                left--;
            end
        end
    endtask

    task automatic drain();
        while (pend_q.size() != 0 || in_ch.valid || inside_q.size() != 0)
            @(posedge i_clk);
        repeat (DERIVE_WAIT) @(posedge i_clk);
    endtask

    task automatic write_threshold(logic [15:0] v);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= v;
        do @(posedge i_clk); while (!cfg_ch.ready);
        thr_q         = v;
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic push_directed();
        logic signed [31:0] mx;
        logic signed [31:0] mn;
        mx = 32'sh7fffffff;
        mn = 32'sh80000000;
        // planes are still zero after reset
        pend_q.push_back(box_req(mn, mn, mn, mx, mx, mx));
        pend_q.push_back(box_req(0, 0, 0, 0, 0, 0));
        // all-zero matrix: every normal has zero length
        for (int i = 0; i < 16; i++)
            pend_q.push_back(load_req(i, 0));
        pend_q.push_back(box_req(mx, mx, mx, mn, mn, mn));
        // frustum-like matrix, elements in order
        for (int i = 0; i < 16; i++)
            pend_q.push_back(load_req(i, (i % 5 == 0) ? 32'sh10000 :
                                         (i == 14) ? -32'sh8000 : 32'sh0));
        pend_q.push_back(load_req(11, -32'sh10000));
        pend_q.push_back(load_req(15, mx));
        pend_q.push_back(box_req(-32'sh1000, -32'sh1000, -32'sh1000,
                                 32'sh1000, 32'sh1000, 32'sh1000));
        pend_q.push_back(box_req(mn, mn, mn, mx, mx, mx));
        // inverted box
        pend_q.push_back(box_req(32'sh1000, 32'sh1000, 32'sh1000,
                                 -32'sh1000, -32'sh1000, -32'sh1000));
        pend_q.push_back(load_req(15, mn));
        pend_q.push_back(box_req(0, 0, 0, 0, 0, 0));
    endtask

    initial begin
        errors    = 0;
        cycles    = 0;
        hold_req  = 0;
        thr_q     = THR_RESET;
        src_idle  = 24;
        sink_idle = 82;
        foreach (mat[i]) mat[i] = 0;
        foreach (norm[i]) norm[i] = 0;
        foreach (offs[i]) offs[i] = 0;
        cfg_ch.valid = 1'b0;
        cfg_ch.data  = '0;
        i_rst_n      = 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        push_directed();
        push_random(220);
        drain();

        write_threshold(16'd0);
        push_random(220);
        drain();

        src_idle  = 82;
        sink_idle = 24;
        write_threshold(16'hffff);
        push_random(180);
        drain();

        src_idle  = 0;
        sink_idle = 0;
        write_threshold(16'($urandom));
        push_random(110);
        while (pend_q.size() > 70) @(posedge i_clk);
        hold_req = hold_req + 1;
        // sender waits for every verdict before the last batch
        while (pend_q.size() != 0 || in_ch.valid || inside_q.size() != 0)
            @(posedge i_clk);
        push_random(100);
        drain();

        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule
